### rtl/core/fsvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvr_pkg
// Shared constants, codes and control types of the first-seen renumbering
// dictionary.
// ----------------------------------------------------------------------------
package fsvr_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ID_LIMIT    = 256;
   localparam int CAPACITY    = (TABLE_DEPTH < ID_LIMIT) ? TABLE_DEPTH : ID_LIMIT;
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   localparam int KIND_W   = 2;
   localparam int COLOR_W  = 32;
   localparam int ID_W     = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DECODE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNASSIGNED = 2'd2;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic enc_done;
      logic dec_read;
      logic dec_done;
      logic misc_done;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
   } sts_type;

endpackage

### rtl/core/fsvr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvr_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface fsvr_req_if;
   logic                            valid;
   logic                            ready;
   logic [fsvr_pkg::KIND_W-1:0]     kind;
   logic [fsvr_pkg::COLOR_W-1:0]    color_value;
   logic [fsvr_pkg::ID_W-1:0]       dense_id;

   modport source (output valid, kind, color_value, dense_id, input ready);
   modport sink   (input valid, kind, color_value, dense_id, output ready);
endinterface

interface fsvr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fsvr_pkg::ID_W-1:0]       id_out;
   logic [fsvr_pkg::COLOR_W-1:0]    color_out;
   logic                            was_new;
   logic [fsvr_pkg::COUNT_W-1:0]    distinct_count;
   logic [fsvr_pkg::STATUS_W-1:0]   status;

   modport source (output valid, id_out, color_out, was_new, distinct_count, status,
                   input ready);
   modport sink   (input valid, id_out, color_out, was_new, distinct_count, status,
                   output ready);
endinterface

### rtl/core/fsvr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvr_ctrl
// Sequencer: accepts a request word, steps the datapath through the search,
// decode, clear or unused-kind reply, then holds the response word until it is taken.
// ----------------------------------------------------------------------------
module fsvr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [fsvr_pkg::KIND_W-1:0] req_kind,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  fsvr_pkg::sts_type           sts,
   output fsvr_pkg::cmd_type           cmd
);
   import fsvr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DREAD = 3'd2;
   localparam logic [2:0] ST_DFIN  = 3'd3;
   localparam logic [2:0] ST_MISC  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_kind == KIND_ENCODE) begin
                  state_in = ST_SCAN;
               end else if (req_kind == KIND_DECODE) begin
                  state_in = ST_DREAD;
               end else begin
                  state_in = ST_MISC;
               end
            end
         end
         ST_SCAN: begin
            if (sts.hit || sts.scan_end) begin
               cmd.enc_done = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DREAD: begin
            cmd.dec_read = 1'b1;
            state_in     = ST_DFIN;
         end
         ST_DFIN: begin
            cmd.dec_done = 1'b1;
            state_in     = ST_RESP;
         end
         ST_MISC: begin
            cmd.misc_done = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/fsvr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvr_dpath
// Dictionary datapath: color memory, entry count, pipelined linear search
// and the response word register.
// ----------------------------------------------------------------------------
module fsvr_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  fsvr_pkg::cmd_type               cmd,
   output fsvr_pkg::sts_type               sts,
   input  logic [fsvr_pkg::KIND_W-1:0]     req_kind,
   input  logic [fsvr_pkg::COLOR_W-1:0]    req_color_value,
   input  logic [fsvr_pkg::ID_W-1:0]       req_dense_id,
   output logic [fsvr_pkg::ID_W-1:0]       rsp_id_out,
   output logic [fsvr_pkg::COLOR_W-1:0]    rsp_color_out,
   output logic                            rsp_was_new,
   output logic [fsvr_pkg::COUNT_W-1:0]    rsp_distinct_count,
   output logic [fsvr_pkg::STATUS_W-1:0]   rsp_status
);
   import fsvr_pkg::*;

   logic [COLOR_W-1:0]  mem [CAPACITY];
   logic [COLOR_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;

   logic [KIND_W-1:0]   kind_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [ID_W-1:0]     did_ff;
   logic [CNT_W-1:0]    cnt_ff,  cnt_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pidx_ff;

   logic [ID_W-1:0]     id_ff,     id_in;
   logic [COLOR_W-1:0]  cout_ff,   cout_in;
   logic                new_ff,    new_in;
   logic [COUNT_W-1:0]  dc_ff,     dc_in;
   logic [STATUS_W-1:0] stat_ff,   stat_in;

   logic issue;
   logic full;
   logic id_valid;

   assign issue    = scan_ff < cnt_ff;
   assign full     = cnt_ff >= CNT_W'(CAPACITY);
   assign id_valid = COUNT_W'(did_ff) < COUNT_W'(cnt_ff);

   assign sts.hit      = pend_ff && (rd_data_ff == color_ff);
   assign sts.scan_end = !issue && !pend_ff;

   assign rd_addr = cmd.dec_read ? did_ff[ADDR_W-1:0] : scan_ff[ADDR_W-1:0];
   assign wr_en   = cmd.enc_done && !sts.hit && !full;

   always_comb begin
      cnt_in  = cnt_ff;
      scan_in = scan_ff;
      pend_in = pend_ff;
      id_in   = id_ff;
      cout_in = cout_ff;
      new_in  = new_ff;
      dc_in   = dc_ff;
      stat_in = stat_ff;
      if (cmd.load) begin
         scan_in = '0;
         pend_in = 1'b0;
      end
      if (cmd.scan_step) begin
         pend_in = issue;
         if (issue) begin
            scan_in = scan_ff + 1'b1;
         end
      end
      if (cmd.enc_done) begin
         cout_in = color_ff;
         if (sts.hit) begin
            id_in   = ID_W'(pidx_ff);
            new_in  = 1'b0;
            dc_in   = COUNT_W'(cnt_ff);
            stat_in = STATUS_OK;
         end else if (full) begin
            id_in   = '0;
            new_in  = 1'b0;
            dc_in   = COUNT_W'(cnt_ff);
            stat_in = STATUS_FULL;
         end else begin
            id_in   = ID_W'(cnt_ff);
            new_in  = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            dc_in   = COUNT_W'(cnt_ff) + 1'b1;
            stat_in = STATUS_OK;
         end
      end
      if (cmd.dec_done) begin
         id_in  = did_ff;
         new_in = 1'b0;
         dc_in  = COUNT_W'(cnt_ff);
         if (id_valid) begin
            cout_in = rd_data_ff;
            stat_in = STATUS_OK;
         end else begin
            cout_in = '0;
            stat_in = STATUS_UNASSIGNED;
         end
      end
      if (cmd.misc_done) begin
         id_in   = '0;
         cout_in = '0;
         new_in  = 1'b0;
         stat_in = STATUS_OK;
         if (kind_ff == KIND_CLEAR) begin
            cnt_in = '0;
            dc_in  = '0;
         end else begin
            dc_in = COUNT_W'(cnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[ADDR_W-1:0]] <= color_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         color_ff <= req_color_value;
         did_ff   <= req_dense_id;
      end
      pidx_ff <= scan_ff[ADDR_W-1:0];
      scan_ff <= scan_in;
      id_ff   <= id_in;
      cout_ff <= cout_in;
      new_ff  <= new_in;
      dc_ff   <= dc_in;
      stat_ff <= stat_in;
   end

   assign rsp_id_out         = id_ff;
   assign rsp_color_out      = cout_ff;
   assign rsp_was_new        = new_ff;
   assign rsp_distinct_count = dc_ff;
   assign rsp_status         = stat_ff;

endmodule

### rtl/core/first_seen_value_renumbering.sv
`timescale 1ns / 1ps
// Encode: the held entries are read in order, one entry read per cycle plus a compare
//    stage, until a hit or the last entry is compared; decode reads the entry at the given
//    id, and clear and unused kinds answer without a memory read.
// Flow: one word in flight; the next request is accepted from the cycle after the
//    response is taken.
// Reset: synchronous, active high; empties the dictionary (entry count to zero) at once.
// ----------------------------------------------------------------------------
// first_seen_value_renumbering
// Dictionary encoder giving each distinct 32-bit color a dense id in order of
// first appearance, with id-to-color decode and clear.
// ----------------------------------------------------------------------------
module first_seen_value_renumbering (
   input  logic       clock,
   input  logic       reset,
   fsvr_req_if.sink   req_ch,
   fsvr_rsp_if.source rsp_ch
);
   import fsvr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fsvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsvr_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_kind           (req_ch.kind),
      .req_color_value    (req_ch.color_value),
      .req_dense_id       (req_ch.dense_id),
      .rsp_id_out         (rsp_ch.id_out),
      .rsp_color_out      (rsp_ch.color_out),
      .rsp_was_new        (rsp_ch.was_new),
      .rsp_distinct_count (rsp_ch.distinct_count),
      .rsp_status         (rsp_ch.status)
   );

endmodule
